// File: sv/pli_pkg.sv
// Package for the point list block: field widths, action and status codes,
// default sizes and the control structs shared by the list modules.
// No dependencies.
package pli_pkg;

   localparam int ACTION_W      = 3;
   localparam int POS_W         = 5;
   localparam int FIELD_W       = 32;
   localparam int COUNT_OUT_W   = 5;
   localparam int STATUS_W      = 2;

   localparam int CAPACITY_DEFAULT    = 16;
   localparam int COORD_WIDTH_DEFAULT = 32;

   localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_GET    = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic ins;
      logic rem;
   } store_op_type;

   typedef struct packed {
      logic                get_ok;
      logic [STATUS_W-1:0] status;
   } rsp_ctrl_type;

endpackage

// File: sv/pli_ctrl.sv
// Request decode and entry count for the point list.
// Checks positions against the count, picks the shift operation and status.
// Depends on pli_pkg.
module pli_ctrl #(
   parameter int CAPACITY = pli_pkg::CAPACITY_DEFAULT,
   parameter int COUNT_W  = $clog2(CAPACITY + 1),
   parameter int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            valid,
   input  logic [pli_pkg::ACTION_W-1:0]    action,
   input  logic [pli_pkg::POS_W-1:0]       position,
   output pli_pkg::store_op_type           op,
   output logic [IDX_W-1:0]                idx,
   output pli_pkg::rsp_ctrl_type           rsp,
   output logic [pli_pkg::COUNT_OUT_W-1:0] entry_count
);

   localparam int W0    = (COUNT_W > pli_pkg::POS_W) ? COUNT_W : pli_pkg::POS_W;
   localparam int CMP_W = (W0 > pli_pkg::COUNT_OUT_W) ? W0 : pli_pkg::COUNT_OUT_W;

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [CMP_W-1:0]   cnt_ext;
   logic [CMP_W-1:0]   pos_ext;
   logic [CMP_W-1:0]   cnt_next_ext;
   logic               full;

   assign cnt_ext      = CMP_W'(count_ff);
   assign pos_ext      = CMP_W'(position);
   assign full         = (count_ff >= COUNT_W'(CAPACITY));
   assign cnt_next_ext = CMP_W'(count_in);
   assign entry_count  = cnt_next_ext[pli_pkg::COUNT_OUT_W-1:0];

   always_comb begin
      op         = '0;
      idx        = '0;
      rsp.get_ok = 1'b0;
      rsp.status = pli_pkg::ST_DONE;
      count_in   = count_ff;
      if (valid) begin
         unique case (action)
            pli_pkg::ACT_APPEND: begin
               if (full) begin
                  rsp.status = pli_pkg::ST_FULL;
               end else begin
                  op.ins   = 1'b1;
                  idx      = count_ff[IDX_W-1:0];
                  count_in = count_ff + COUNT_W'(1);
               end
            end
            pli_pkg::ACT_INSERT: begin
               if (pos_ext > cnt_ext) begin
                  rsp.status = pli_pkg::ST_RANGE;
               end else if (full) begin
                  rsp.status = pli_pkg::ST_FULL;
               end else begin
                  op.ins   = 1'b1;
                  idx      = pos_ext[IDX_W-1:0];
                  count_in = count_ff + COUNT_W'(1);
               end
            end
            pli_pkg::ACT_REMOVE: begin
               if (pos_ext >= cnt_ext) begin
                  rsp.status = pli_pkg::ST_RANGE;
               end else begin
                  op.rem   = 1'b1;
                  idx      = pos_ext[IDX_W-1:0];
                  count_in = count_ff - COUNT_W'(1);
               end
            end
            pli_pkg::ACT_GET: begin
               if (pos_ext >= cnt_ext) begin
                  rsp.status = pli_pkg::ST_RANGE;
               end else begin
                  rsp.get_ok = 1'b1;
                  idx        = pos_ext[IDX_W-1:0];
               end
            end
            pli_pkg::ACT_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_op_excl: assert property (@(posedge clock) disable iff (reset)
      !(op.ins && op.rem))
      else $error("insert and remove at once");

   a_err_hold: assert property (@(posedge clock) disable iff (reset)
      (valid && rsp.status != pli_pkg::ST_DONE) |=> (count_ff == $past(count_ff)))
      else $error("count changed on a failed item");
`endif

endmodule

// File: sv/pli_store.sv
// Point storage: one register per entry, shifting up on insert and down on
// remove, with a read port at the request index. Depends on pli_pkg.
module pli_store #(
   parameter int CAPACITY    = pli_pkg::CAPACITY_DEFAULT,
   parameter int COORD_WIDTH = pli_pkg::COORD_WIDTH_DEFAULT,
   parameter int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                   clock,
   input  pli_pkg::store_op_type  op,
   input  logic [IDX_W-1:0]       idx,
   input  logic [COORD_WIDTH-1:0] new_x,
   input  logic [COORD_WIDTH-1:0] new_y,
   output logic [COORD_WIDTH-1:0] rd_x,
   output logic [COORD_WIDTH-1:0] rd_y
);

   logic [COORD_WIDTH-1:0] x_ff [CAPACITY];
   logic [COORD_WIDTH-1:0] y_ff [CAPACITY];
   logic [COORD_WIDTH-1:0] x_in [CAPACITY];
   logic [COORD_WIDTH-1:0] y_in [CAPACITY];

   assign rd_x = x_ff[idx];
   assign rd_y = y_ff[idx];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_entry
      always_comb begin
         x_in[i] = x_ff[i];
         y_in[i] = y_ff[i];
         if (op.ins) begin
            if (IDX_W'(i) == idx) begin
               x_in[i] = new_x;
               y_in[i] = new_y;
            end else if (IDX_W'(i) > idx) begin
               x_in[i] = x_ff[(i > 0) ? i - 1 : 0];
               y_in[i] = y_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (op.rem) begin
            if ((IDX_W'(i) >= idx) && (i < CAPACITY - 1)) begin
               x_in[i] = x_ff[(i < CAPACITY - 1) ? i + 1 : i];
               y_in[i] = y_ff[(i < CAPACITY - 1) ? i + 1 : i];
            end
         end
      end

      always_ff @(posedge clock) begin
         x_ff[i] <= x_in[i];
         y_ff[i] <= y_in[i];
      end
   end

endmodule

// File: sv/point_list_insert_remove.sv
// Ordered point list with append, positional insert and remove, get, clear.
// Each item passes a request register, then a result register, before the result
// strobe rises. Throughput: one item every
// cycle; busy never rises and the receiver cannot stall. Synchronous reset empties
// the list and drops items in flight; entry storage is not cleared.
// Depends on pli_pkg, pli_ctrl, pli_store.
module point_list_insert_remove #(
   parameter int CAPACITY    = pli_pkg::CAPACITY_DEFAULT,
   parameter int COORD_WIDTH = pli_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic        [pli_pkg::ACTION_W-1:0] req_action,
   input  logic        [pli_pkg::POS_W-1:0]    req_position,
   input  logic signed [pli_pkg::FIELD_W-1:0]  req_point_x,
   input  logic signed [pli_pkg::FIELD_W-1:0]  req_point_y,
   output logic                                rsp_valid,
   output logic signed [pli_pkg::FIELD_W-1:0]  rsp_read_x,
   output logic signed [pli_pkg::FIELD_W-1:0]  rsp_read_y,
   output logic [pli_pkg::COUNT_OUT_W-1:0]     rsp_entry_count,
   output logic [pli_pkg::STATUS_W-1:0]        rsp_status
);

   localparam int COUNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic                         req_valid_ff;
   logic [pli_pkg::ACTION_W-1:0] req_action_ff;
   logic [pli_pkg::POS_W-1:0]    req_position_ff;
   logic [COORD_WIDTH-1:0]       req_x_ff;
   logic [COORD_WIDTH-1:0]       req_y_ff;

   logic                                rsp_valid_ff;
   logic signed [pli_pkg::FIELD_W-1:0]  rsp_read_x_ff;
   logic signed [pli_pkg::FIELD_W-1:0]  rsp_read_y_ff;
   logic [pli_pkg::COUNT_OUT_W-1:0]     rsp_count_ff;
   logic [pli_pkg::STATUS_W-1:0]        rsp_status_ff;

   pli_pkg::store_op_type               op;
   pli_pkg::rsp_ctrl_type               rsp_ctrl;
   logic [IDX_W-1:0]                    idx;
   logic [pli_pkg::COUNT_OUT_W-1:0]     entry_count;
   logic signed [COORD_WIDTH-1:0]       rd_x;
   logic signed [COORD_WIDTH-1:0]       rd_y;
   logic                                accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_action_ff   <= req_action;
         req_position_ff <= req_position;
         req_x_ff        <= req_point_x[COORD_WIDTH-1:0];
         req_y_ff        <= req_point_y[COORD_WIDTH-1:0];
      end
   end

   pli_ctrl #(
      .CAPACITY (CAPACITY),
      .COUNT_W  (COUNT_W),
      .IDX_W    (IDX_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .valid       (req_valid_ff),
      .action      (req_action_ff),
      .position    (req_position_ff),
      .op          (op),
      .idx         (idx),
      .rsp         (rsp_ctrl),
      .entry_count (entry_count)
   );

   pli_store #(
      .CAPACITY    (CAPACITY),
      .COORD_WIDTH (COORD_WIDTH),
      .IDX_W       (IDX_W)
   ) u_store (
      .clock (clock),
      .op    (op),
      .idx   (idx),
      .new_x (req_x_ff),
      .new_y (req_y_ff),
      .rd_x  (rd_x),
      .rd_y  (rd_y)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_read_x_ff <= rsp_ctrl.get_ok ? pli_pkg::FIELD_W'(rd_x) : '0;
         rsp_read_y_ff <= rsp_ctrl.get_ok ? pli_pkg::FIELD_W'(rd_y) : '0;
         rsp_count_ff  <= entry_count;
         rsp_status_ff <= rsp_ctrl.status;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_x      = rsp_read_x_ff;
   assign rsp_read_y      = rsp_read_y_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

`ifndef SYNTHESIS
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_valid_ff))
      else $error("result strobe without an item in flight");

   a_busy_low: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= pli_pkg::ST_FULL))
      else $error("unknown status code on a result");
`endif

endmodule

// File: dv/pli_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the point list testbench: keeps its own copy of the list,
// works out the result of each accepted item and checks the block's results in order.
// Depends on pli_pkg.
package pli_tb_pkg;
   import pli_pkg::*;

   class point_list_scoreboard;
      typedef struct packed {
         logic signed [FIELD_W-1:0]  read_x;
         logic signed [FIELD_W-1:0]  read_y;
         logic [COUNT_OUT_W-1:0]     entry_count;
         logic [STATUS_W-1:0]        status;
      } list_result_type;

      logic signed [FIELD_W-1:0] stored_x [CAPACITY_DEFAULT];
      logic signed [FIELD_W-1:0] stored_y [CAPACITY_DEFAULT];
      int unsigned               held;
      list_result_type           pending_results [$];
      int unsigned               mismatches;
      int unsigned               checked;
      int unsigned               action_seen [2**ACTION_W];
      int unsigned               full_hits;
      int unsigned               range_hits;
      int unsigned               peak_held;

      function new();
         held       = 0;
         mismatches = 0;
         checked    = 0;
         full_hits  = 0;
         range_hits = 0;
         peak_held  = 0;
         foreach (action_seen[i]) action_seen[i] = 0;
      endfunction

      function void note_request(input logic [ACTION_W-1:0]      action,
                                 input logic [POS_W-1:0]         pos,
                                 input logic signed [FIELD_W-1:0] px,
                                 input logic signed [FIELD_W-1:0] py);
         list_result_type r;
         int unsigned     i;
         r        = '0;
         r.status = ST_DONE;
         case (action)
            ACT_APPEND: begin
               if (held >= CAPACITY_DEFAULT) begin
                  r.status = ST_FULL;
               end else begin
                  stored_x[held] = px;
                  stored_y[held] = py;
                  held++;
               end
            end
            ACT_INSERT: begin
               if (pos > held) begin
                  r.status = ST_RANGE;
               end else if (held >= CAPACITY_DEFAULT) begin
                  r.status = ST_FULL;
               end else begin
                  for (i = held; i > pos; i--) begin
                     stored_x[i] = stored_x[i-1];
                     stored_y[i] = stored_y[i-1];
                  end
                  stored_x[pos] = px;
                  stored_y[pos] = py;
                  held++;
               end
            end
            ACT_REMOVE: begin
               if (pos >= held) begin
                  r.status = ST_RANGE;
               end else begin
                  for (i = pos; i + 1 < held; i++) begin
                     stored_x[i] = stored_x[i+1];
                     stored_y[i] = stored_y[i+1];
                  end
                  held--;
               end
            end
            ACT_GET: begin
               if (pos >= held) begin
                  r.status = ST_RANGE;
               end else begin
                  r.read_x = stored_x[pos];
                  r.read_y = stored_y[pos];
               end
            end
            ACT_CLEAR: held = 0;
            default: ;
         endcase
         r.entry_count = held[COUNT_OUT_W-1:0];
         pending_results = {pending_results, r};
         action_seen[action]++;
         if (r.status == ST_FULL) full_hits++;
         if (r.status == ST_RANGE) range_hits++;
         if (held > peak_held) peak_held = held;
      endfunction

      task report_mismatch(input string what, input logic [FIELD_W-1:0] got,
                           input logic [FIELD_W-1:0] want);
         mismatches++;
         $display("item %0d: %s got 0x%08h, expected 0x%08h", checked, what, got, want);
      endtask

      task check_result(input logic signed [FIELD_W-1:0] rx,
                        input logic signed [FIELD_W-1:0] ry,
                        input logic [COUNT_OUT_W-1:0]    cnt,
                        input logic [STATUS_W-1:0]       st);
         list_result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result, status", FIELD_W'(st), '0);
         end else begin
            want = pending_results.pop_front();
            if (rx !== want.read_x) report_mismatch("read_x", rx, want.read_x);
            if (ry !== want.read_y) report_mismatch("read_y", ry, want.read_y);
            if (cnt !== want.entry_count)
               report_mismatch("entry_count", FIELD_W'(cnt), FIELD_W'(want.entry_count));
            if (st !== want.status)
               report_mismatch("status", FIELD_W'(st), FIELD_W'(want.status));
         end
         checked++;
      endtask

      function int unsigned outstanding();
         return pending_results.size();
      endfunction
   endclass

endpackage

// File: dv/tb_point_list_insert_remove.sv
`timescale 1ns / 1ps
// Testbench top for point_list_insert_remove: directed list edge cases, then
// random fill and drain traffic under three sender idling phases.
// Depends on pli_pkg, pli_tb_pkg and the block's RTL.
module tb_point_list_insert_remove;
   import pli_pkg::*;
   import pli_tb_pkg::*;

   localparam int                  WATCHDOG_LIMIT = 1000;
   localparam int                  PHASE_ITEMS    = 440;
   localparam logic [ACTION_W-1:0] ACT_LAST       = {ACTION_W{1'b1}};
   localparam logic signed [FIELD_W-1:0] COORD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
   localparam logic signed [FIELD_W-1:0] COORD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

   logic                        clock        = 1'b0;
   logic                        reset        = 1'b1;
   logic                        start        = 1'b0;
   logic                        busy;
   logic [ACTION_W-1:0]         req_action   = ACT_GET;
   logic [POS_W-1:0]            req_position = '0;
   logic signed [FIELD_W-1:0]   req_point_x  = '0;
   logic signed [FIELD_W-1:0]   req_point_y  = '0;
   logic                        rsp_valid;
   logic signed [FIELD_W-1:0]   rsp_read_x;
   logic signed [FIELD_W-1:0]   rsp_read_y;
   logic [COUNT_OUT_W-1:0]      rsp_entry_count;
   logic [STATUS_W-1:0]         rsp_status;

   point_list_scoreboard sb;
   int unsigned          stalled_cycles = 0;
   bit                   filling        = 1'b1;

   point_list_insert_remove #(
      .CAPACITY    (CAPACITY_DEFAULT),
      .COORD_WIDTH (COORD_WIDTH_DEFAULT)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_position    (req_position),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .rsp_valid       (rsp_valid),
      .rsp_read_x      (rsp_read_x),
      .rsp_read_y      (rsp_read_y),
      .rsp_entry_count (rsp_entry_count),
      .rsp_status      (rsp_status)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result(rsp_read_x, rsp_read_y, rsp_entry_count, rsp_status);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stalled_cycles <= 0;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
         if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   task automatic send_item(input logic [ACTION_W-1:0] act, input logic [POS_W-1:0] pos,
                            input logic signed [FIELD_W-1:0] px,
                            input logic signed [FIELD_W-1:0] py);
      start        <= 1'b1;
      req_action   <= act;
      req_position <= pos;
      req_point_x  <= px;
      req_point_y  <= py;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(act, pos, px, py);
   endtask

   task automatic sender_gap(input int unsigned pct);
      if (pct != 0 && $urandom_range(99, 0) < pct) begin
         start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99, 0) < pct) @(posedge clock);
      end
   endtask

   function automatic logic signed [FIELD_W-1:0] pick_coord();
      case ($urandom_range(19, 0))
         0:       return COORD_MAX;
         1:       return COORD_MIN;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_item();
      logic [ACTION_W-1:0] act;
      logic [POS_W-1:0]    pos;
      int unsigned         roll;
      int unsigned         cnt;
      cnt = sb.held;
      if (cnt >= CAPACITY_DEFAULT && $urandom_range(3, 0) == 0) filling = 1'b0;
      if (cnt == 0 && $urandom_range(2, 0) == 0) filling = 1'b1;
      if ($urandom_range(49, 0) == 0) filling = !filling;
      roll = $urandom_range(99, 0);
      if (roll < 2)
         act = ACTION_W'($urandom_range(ACT_LAST, ACT_CLEAR + 1));
      else if (roll < 4)
         act = ACT_CLEAR;
      else if (roll < 30)
         act = ACT_GET;
      else if (filling)
         act = (roll < 55) ? ACT_APPEND : (roll < 80) ? ACT_INSERT : ACT_REMOVE;
      else
         act = (roll < 40) ? ACT_APPEND : (roll < 50) ? ACT_INSERT : ACT_REMOVE;
      pos = POS_W'($urandom_range(2**POS_W - 1, 0));
      if ($urandom_range(99, 0) < 85) begin
         if (act == ACT_INSERT)
            pos = POS_W'($urandom_range(cnt, 0));
         else if ((act == ACT_REMOVE || act == ACT_GET) && cnt != 0)
            pos = POS_W'($urandom_range(cnt - 1, 0));
      end
      send_item(act, pos, pick_coord(), pick_coord());
   endtask

   initial begin
      int unsigned gap_pct [3];
      gap_pct = '{7, 55, 0};
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty list, then small-list insert, get and remove cases and unused action codes
      send_item(ACT_GET,    5'd0,  COORD_MAX, COORD_MIN);
      send_item(ACT_REMOVE, 5'd0,  COORD_MAX, COORD_MIN);
      send_item(ACT_CLEAR,  5'd31, COORD_MAX, COORD_MAX);
      send_item(ACT_APPEND, 5'd31, COORD_MAX, COORD_MIN);
      send_item(ACT_APPEND, 5'd0,  COORD_MIN, COORD_MAX);
      send_item(ACT_INSERT, 5'd0,  32'sd1, -32'sd1);
      send_item(ACT_INSERT, 5'd3,  -32'sd2, 32'sd2);
      send_item(ACT_INSERT, 5'd6,  32'sd5, 32'sd5);
      send_item(ACT_GET,    5'd0,  '0, '0);
      send_item(ACT_GET,    5'd3,  '0, '0);
      send_item(ACT_GET,    5'd4,  '0, '0);
      send_item(ACT_REMOVE, 5'd1,  '0, '0);
      send_item(ACT_CLEAR + 3'd1, 5'd0, '1, '1);
      send_item(ACT_LAST,   5'd31, '1, '1);
      // fill to capacity, then hit the full and out-of-range cases and clear
      while (sb.held < CAPACITY_DEFAULT)
         send_item(ACT_APPEND, 5'd0, $urandom, $urandom);
      send_item(ACT_APPEND, 5'd0,  32'sd7, 32'sd7);
      send_item(ACT_INSERT, 5'd5,  32'sd7, 32'sd7);
      send_item(ACT_INSERT, 5'd17, 32'sd7, 32'sd7);
      send_item(ACT_GET,    5'd15, '0, '0);
      send_item(ACT_REMOVE, 5'd15, '0, '0);
      send_item(ACT_CLEAR,  5'd0,  '0, '0);

      foreach (gap_pct[p])
         repeat (PHASE_ITEMS) begin
            sender_gap(gap_pct[p]);
            random_item();
         end

      start <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (6) @(posedge clock);

      $display("%0d results checked: %0d appends, %0d inserts, %0d removes, %0d gets, %0d clears",
               sb.checked, sb.action_seen[ACT_APPEND], sb.action_seen[ACT_INSERT],
               sb.action_seen[ACT_REMOVE], sb.action_seen[ACT_GET], sb.action_seen[ACT_CLEAR]);
      $display("list full flagged %0d times, out of range %0d times, peak length %0d",
               sb.full_hits, sb.range_hits, sb.peak_held);
      if (sb.mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// File: point_list_insert_remove.f
sv/pli_pkg.sv
sv/pli_ctrl.sv
sv/pli_store.sv
sv/point_list_insert_remove.sv
dv/pli_tb_pkg.sv
dv/tb_point_list_insert_remove.sv
